>>> rtl/core/tst_pkg.sv
package tst_pkg;

    localparam int START_W = 31;
    localparam int OFF_W   = 32;

    localparam logic [1:0] ACT_LOOKUP  = 2'd0;
    localparam logic [1:0] ACT_INSERT  = 2'd1;
    localparam logic [1:0] ACT_REPLACE = 2'd2;
    localparam logic [1:0] ACT_READ    = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_MISS   = 3'd1;
    localparam logic [2:0] ST_RANGE  = 3'd2;
    localparam logic [2:0] ST_BADLEN = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         segment_index;
        logic [15:0]        found_source;
        logic [32:0]        source_frame;
        logic [START_W-1:0] start_frame;
        logic [6:0]         segment_count;
    } result_t;

endpackage

>>> rtl/core/tst_mem.sv
module tst_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 103
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/tst_ctrl.sv
module tst_ctrl #(
    parameter int MAX_SEGMENTS   = 64,
    parameter int LENGTH_BITS    = 24,
    parameter int SOURCE_ID_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            action,
    input  logic [31:0]           frame_index,
    input  logic [7:0]            position,
    input  logic [15:0]           source_id,
    input  logic [31:0]           segment_offset,
    input  logic [24:0]           segment_length,
    output logic                  idle,
    output logic                  res_valid,
    input  logic                  res_take,
    output tst_pkg::result_t      res
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int PW = ((CW > 8) ? CW : 8) + 2;
    localparam int SB = SOURCE_ID_BITS;
    localparam int LB = LENGTH_BITS;
    localparam int SW = tst_pkg::START_W;
    localparam int OW = tst_pkg::OFF_W;
    localparam int EW = SW + 2;
    localparam int MW = SB + OW + LB + SW;
    localparam logic [31:0] LEN_MAX = (32'd1 << LB) - 32'd1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_LOOK   = 4'd2;
    localparam logic [3:0] S_SHIFT  = 4'd3;
    localparam logic [3:0] S_PREV   = 4'd4;
    localparam logic [3:0] S_FILL   = 4'd5;
    localparam logic [3:0] S_RIPPLE = 4'd6;
    localparam logic [3:0] S_RDWAIT = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic [1:0]    act_reg, act_next;
    logic [31:0]   frame_reg, frame_next;
    logic [7:0]    pos_reg, pos_next;
    logic [SB-1:0] src_reg, src_next;
    logic [OW-1:0] off_reg, off_next;
    logic [24:0]   len_reg, len_next;
    logic [AW-1:0] iter_reg, iter_next;
    logic [AW-1:0] p_reg, p_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic          back_reg, back_next;
    logic [2:0]    rst_reg, rst_next;
    logic [AW-1:0] ridx_reg, ridx_next;
    logic [SB-1:0] rsrc_reg, rsrc_next;
    logic [32:0]   rsf_reg, rsf_next;
    logic [SW-1:0] rstart_reg, rstart_next;

    logic          we, re;
    logic [AW-1:0] wa, ra;
    logic [MW-1:0] wd, rd;
    logic [SB-1:0] rd_src;
    logic [OW-1:0] rd_off;
    logic [LB-1:0] rd_len;
    logic [SW-1:0] rd_start;

    logic signed [PW-1:0] pos_s, cnt_s, pe, ins_pos;
    logic          len_ok;
    logic [LB-1:0] len_st;
    logic [EW-1:0] seg_end;
    logic [EW-1:0] fr;
    logic [EW-1:0] st_ext;
    logic          last_seg;
    logic [CW-1:0] iter_inc;
    logic [CW-1:0] count_ins;
    logic [SW-1:0] base;
    logic signed [33:0] sf_full;

    assign {rd_src, rd_off, rd_len, rd_start} = rd;

    assign pos_s   = PW'($signed(pos_reg));
    assign cnt_s   = $signed({{(PW-CW){1'b0}}, count_reg});
    assign pe      = (pos_s < 0) ? pos_s + cnt_s : pos_s;
    assign ins_pos = (pe < 0) ? '0 : pe;
    assign len_ok  = !len_reg[24] && (len_reg != '0) && (32'(len_reg[23:0]) <= LEN_MAX);
    assign len_st  = LB'(len_reg[23:0]);
    assign fr      = EW'(frame_reg);
    assign st_ext  = EW'(rd_start);
    assign seg_end = st_ext + EW'(rd_len);
    assign last_seg = (CW'(iter_reg) == count_reg - CW'(1));
    assign iter_inc = CW'(iter_reg) + CW'(1);
    assign count_ins = (act_reg == tst_pkg::ACT_INSERT) ? count_reg + CW'(1) : count_reg;
    assign base    = (p_reg == '0) ? '0 : SW'(rd_start + SW'(rd_len));
    assign sf_full = $signed({2'b00, frame_reg}) - $signed({3'b000, rd_start})
                   + $signed({{2{rd_off[31]}}, rd_off});

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        act_next    = act_reg;
        frame_next  = frame_reg;
        pos_next    = pos_reg;
        src_next    = src_reg;
        off_next    = off_reg;
        len_next    = len_reg;
        iter_next   = iter_reg;
        p_next      = p_reg;
        sum_next    = sum_reg;
        back_next   = back_reg;
        rst_next    = rst_reg;
        ridx_next   = ridx_reg;
        rsrc_next   = rsrc_reg;
        rsf_next    = rsf_reg;
        rstart_next = rstart_reg;
        we = 1'b0;
        wa = '0;
        wd = rd;
        re = 1'b0;
        ra = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next    = action;
                    frame_next  = frame_index;
                    pos_next    = position;
                    src_next    = SB'(source_id);
                    off_next    = segment_offset;
                    len_next    = segment_length;
                    rst_next    = tst_pkg::ST_OK;
                    ridx_next   = '0;
                    rsrc_next   = '0;
                    rsf_next    = '0;
                    rstart_next = '0;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (act_reg)
                    tst_pkg::ACT_LOOKUP:
                    begin
                        if (frame_reg[31] || count_reg == '0)
                        begin
                            rst_next   = tst_pkg::ST_MISS;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            iter_next = (CW'(cursor_reg) < count_reg) ? cursor_reg
                                      : AW'(count_reg - CW'(1));
                            re = 1'b1;
                            ra = iter_next;
                            back_next  = 1'b0;
                            state_next = S_LOOK;
                        end
                    end
                    tst_pkg::ACT_INSERT:
                    begin
                        if (ins_pos > cnt_s)
                        begin
                            rst_next   = tst_pkg::ST_RANGE;
                            state_next = S_DONE;
                        end
                        else if (count_reg == CW'(MAX_SEGMENTS))
                        begin
                            rst_next   = tst_pkg::ST_FULL;
                            state_next = S_DONE;
                        end
                        else if (!len_ok)
                        begin
                            rst_next   = tst_pkg::ST_BADLEN;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            p_next = AW'(ins_pos);
                            if (cnt_s > ins_pos)
                            begin
                                iter_next  = AW'(count_reg);
                                re = 1'b1;
                                ra = AW'(count_reg - CW'(1));
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                state_next = S_PREV;
                            end
                        end
                    end
                    tst_pkg::ACT_REPLACE:
                    begin
                        if (pos_s < 0 || pos_s >= cnt_s)
                        begin
                            rst_next   = tst_pkg::ST_RANGE;
                            state_next = S_DONE;
                        end
                        else if (!len_ok)
                        begin
                            rst_next   = tst_pkg::ST_BADLEN;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            p_next     = AW'(pos_s);
                            state_next = S_PREV;
                        end
                    end
                    default:
                    begin
                        if (pos_s < 0 || pos_s >= cnt_s)
                        begin
                            rst_next   = tst_pkg::ST_RANGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            iter_next  = AW'(pos_s);
                            re = 1'b1;
                            ra = AW'(pos_s);
                            state_next = S_RDWAIT;
                        end
                    end
                endcase
            end
            S_LOOK:
            begin
                if (!back_reg && !last_seg && fr >= seg_end)
                begin
                    iter_next = iter_reg + AW'(1);
                    re = 1'b1;
                    ra = iter_next;
                end
                else if (iter_reg != '0 && fr < st_ext)
                begin
                    iter_next = iter_reg - AW'(1);
                    back_next = 1'b1;
                    re = 1'b1;
                    ra = iter_next;
                end
                else
                begin
                    cursor_next = iter_reg;
                    if (fr < st_ext || fr >= seg_end)
                    begin
                        rst_next = tst_pkg::ST_MISS;
                    end
                    else
                    begin
                        ridx_next   = iter_reg;
                        rsrc_next   = rd_src;
                        rsf_next    = sf_full[32:0];
                        rstart_next = rd_start;
                    end
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                we = 1'b1;
                wa = iter_reg;
                wd = rd;
                if (iter_reg - AW'(1) > p_reg)
                begin
                    iter_next = iter_reg - AW'(1);
                    re = 1'b1;
                    ra = iter_reg - AW'(2);
                end
                else
                begin
                    state_next = S_PREV;
                end
            end
            S_PREV:
            begin
                re = (p_reg != '0);
                ra = p_reg - AW'(1);
                state_next = S_FILL;
            end
            S_FILL:
            begin
                we = 1'b1;
                wa = p_reg;
                wd = {src_reg, off_reg, len_st, base};
                sum_next    = SW'(base + SW'(len_st));
                ridx_next   = p_reg;
                rstart_next = base;
                count_next  = count_ins;
                if (CW'(p_reg) + CW'(1) < count_ins)
                begin
                    iter_next  = p_reg + AW'(1);
                    re = 1'b1;
                    ra = iter_next;
                    state_next = S_RIPPLE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RIPPLE:
            begin
                we = 1'b1;
                wa = iter_reg;
                wd = {rd_src, rd_off, rd_len, sum_reg};
                sum_next = SW'(sum_reg + SW'(rd_len));
                if (iter_inc < count_reg)
                begin
                    iter_next = iter_reg + AW'(1);
                    re = 1'b1;
                    ra = iter_next;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RDWAIT:
            begin
                ridx_next   = iter_reg;
                rstart_next = rd_start;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        frame_reg  <= frame_next;
        pos_reg    <= pos_next;
        src_reg    <= src_next;
        off_reg    <= off_next;
        len_reg    <= len_next;
        iter_reg   <= iter_next;
        p_reg      <= p_next;
        sum_reg    <= sum_next;
        back_reg   <= back_next;
        rst_reg    <= rst_next;
        ridx_reg   <= ridx_next;
        rsrc_reg   <= rsrc_next;
        rsf_reg    <= rsf_next;
        rstart_reg <= rstart_next;
    end

    tst_mem #(
        .DEPTH (MAX_SEGMENTS),
        .AW    (AW),
        .W     (MW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (we),
        .wr_addr (wa),
        .wr_data (wd),
        .rd_en   (re),
        .rd_addr (ra),
        .rd_data (rd)
    );

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.status        = rst_reg;
        res.segment_index = 6'(ridx_reg);
        res.found_source  = 16'(rsrc_reg);
        res.source_frame  = rsf_reg;
        res.start_frame   = rstart_reg;
        res.segment_count = 7'(count_reg);
    end

endmodule

>>> rtl/core/timeline_segment_table.sv
// Timeline segment table: an ordered list of clip segments held in one
// synchronous memory, with start frames kept as running sums of lengths.
// The slave channel carries one command word; s_tuser holds the action
// (lookup, insert, replace, read) and s_tdata the frame, position, source,
// offset and length. Every command returns exactly one word on the master
// channel with the status in m_tuser and the results in m_tdata.
// A rejected command, or a lookup of a negative frame or in an empty table,
// returns its word without reading the segment memory. A lookup walks the
// segments from the remembered cursor; an insert moves the segments at and
// after its position up one by one, writes the new one and recomputes the
// start frames behind it; a replace recomputes the start frames of the
// segments after it. The segment memory has a single read port, so the
// walks read one entry a cycle. One command is in work at a time; the next
// is accepted the cycle after the previous word enters the output register.
// Reset empties the table and zeroes the cursor; no clearing pass is run.
// When the receiver stalls, the sequencer holds its next result until the
// output register frees up, and no new command is accepted meanwhile.
module timeline_segment_table #(
    parameter int MAX_SEGMENTS   = 64,
    parameter int LENGTH_BITS    = 24,
    parameter int SOURCE_ID_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,  // frame_index, position, source_id,
                                   // segment_offset, segment_length
    input  logic [1:0]   s_tuser,  // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // segment_index, found_source, source_frame,
                                   // start_frame, segment_count
    output logic [2:0]   m_tuser   // status
);

    logic             idle;
    logic             res_valid;
    logic             res_take;
    tst_pkg::result_t res;
    tst_pkg::result_t out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    tst_ctrl #(
        .MAX_SEGMENTS   (MAX_SEGMENTS),
        .LENGTH_BITS    (LENGTH_BITS),
        .SOURCE_ID_BITS (SOURCE_ID_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (s_tvalid && s_tready),
        .action         (s_tuser),
        .frame_index    (s_tdata[31:0]),
        .position       (s_tdata[39:32]),
        .source_id      (s_tdata[55:40]),
        .segment_offset (s_tdata[87:56]),
        .segment_length (s_tdata[112:88]),
        .idle           (idle),
        .res_valid      (res_valid),
        .res_take       (res_take),
        .res            (res)
    );

    assign s_tready = idle;
    assign res_take = res_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        out_next       = res_take ? res : out_reg;
        out_valid_next = res_take || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b000, out_reg.segment_count, out_reg.start_frame,
                       out_reg.source_frame, out_reg.found_source, out_reg.segment_index};

endmodule

>>> tb/tb_timeline_segment_table.sv
`timescale 1ns / 1ps

module tb_timeline_segment_table;

    localparam int TABLE_DEPTH = 64;
    localparam int MAX_LEN     = (1 << 24) - 1;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    class segment_scoreboard;
        logic [15:0]                 sources [TABLE_DEPTH];
        logic [31:0]                 offsets [TABLE_DEPTH];
        int                          lengths [TABLE_DEPTH];
        logic [tst_pkg::START_W-1:0] starts  [TABLE_DEPTH];
        int                          seg_count;
        int                          cursor;
        tst_pkg::result_t            pending [$];
        int                          mismatches;

        function new();
            seg_count  = 0;
            cursor     = 0;
            mismatches = 0;
        endfunction

        function int timeline_end();
            if (seg_count == 0)
                return 0;
            return int'(starts[seg_count-1]) + lengths[seg_count-1];
        endfunction

        function void rebuild_starts(int k);
            if (k == 0)
            begin
                if (seg_count > 0)
                    starts[0] = '0;
                k = 1;
            end
            for (int j = k; j < seg_count; j++)
                starts[j] = starts[j-1] + tst_pkg::START_W'(lengths[j-1]);
        endfunction

        function void note_command(logic [1:0] act, logic signed [31:0] frame,
                                   logic signed [7:0] pos, logic [15:0] src,
                                   logic [31:0] off, logic signed [24:0] len);
            tst_pkg::result_t r;
            int               i;
            int               p;
            longint           sf;
            r = '0;
            p = pos;
            case (act)
                tst_pkg::ACT_LOOKUP:
                begin
                    if (frame < 0 || seg_count == 0)
                        r.status = tst_pkg::ST_MISS;
                    else
                    begin
                        i = (cursor < seg_count) ? cursor : seg_count - 1;
                        while (i < seg_count - 1 &&
                               longint'(frame) >= longint'(starts[i]) + lengths[i])
                            i++;
                        while (i > 0 && longint'(frame) < longint'(starts[i]))
                            i--;
                        cursor = i;
                        if (longint'(frame) < longint'(starts[i]) ||
                            longint'(frame) >= longint'(starts[i]) + lengths[i])
                            r.status = tst_pkg::ST_MISS;
                        else
                        begin
                            sf = longint'(frame) - longint'(starts[i])
                                 + longint'(signed'(offsets[i]));
                            r.status        = tst_pkg::ST_OK;
                            r.segment_index = 6'(i);
                            r.found_source  = sources[i];
                            r.source_frame  = 33'(sf);
                            r.start_frame   = starts[i];
                        end
                    end
                end
                tst_pkg::ACT_INSERT:
                begin
                    if (p < 0)
                        p += seg_count;
                    if (p < 0)
                        p = 0;
                    if (p > seg_count)
                        r.status = tst_pkg::ST_RANGE;
                    else if (seg_count >= TABLE_DEPTH)
                        r.status = tst_pkg::ST_FULL;
                    else if (len < 1 || len > MAX_LEN)
                        r.status = tst_pkg::ST_BADLEN;
                    else
                    begin
                        for (int j = seg_count; j > p; j--)
                        begin
                            sources[j] = sources[j-1];
                            offsets[j] = offsets[j-1];
                            lengths[j] = lengths[j-1];
                            starts[j]  = starts[j-1];
                        end
                        sources[p] = src;
                        offsets[p] = off;
                        lengths[p] = int'(len);
                        seg_count++;
                        rebuild_starts(p);
                        r.segment_index = 6'(p);
                        r.start_frame   = starts[p];
                    end
                end
                tst_pkg::ACT_REPLACE:
                begin
                    if (p < 0 || p >= seg_count)
                        r.status = tst_pkg::ST_RANGE;
                    else if (len < 1 || len > MAX_LEN)
                        r.status = tst_pkg::ST_BADLEN;
                    else
                    begin
                        sources[p] = src;
                        offsets[p] = off;
                        lengths[p] = int'(len);
                        rebuild_starts(p);
                        r.segment_index = 6'(p);
                        r.start_frame   = starts[p];
                    end
                end
                default:
                begin
                    if (p < 0 || p >= seg_count)
                        r.status = tst_pkg::ST_RANGE;
                    else
                    begin
                        r.segment_index = 6'(p);
                        r.start_frame   = starts[p];
                    end
                end
            endcase
            r.segment_count = 7'(seg_count);
            pending.push_back(r);
        endfunction

        function void check_result(logic [2:0] status, logic [95:0] data);
            tst_pkg::result_t got;
            tst_pkg::result_t want;
            got.status        = status;
            got.segment_index = data[5:0];
            got.found_source  = data[21:6];
            got.source_frame  = data[54:22];
            got.start_frame   = data[85:55];
            got.segment_count = data[92:86];
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: status %0d data %h", status, data);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.segment_index !== want.segment_index ||
                got.found_source !== want.found_source ||
                got.source_frame !== want.source_frame ||
                got.start_frame !== want.start_frame ||
                got.segment_count !== want.segment_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Mismatch: expected st %0d idx %0d src %h sf %h start %0d cnt %0d",
                             want.status, want.segment_index, want.found_source,
                             want.source_frame, want.start_frame, want.segment_count);
                    $display("          got      st %0d idx %0d src %h sf %h start %0d cnt %0d",
                             got.status, got.segment_index, got.found_source,
                             got.source_frame, got.start_frame, got.segment_count);
                end
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [2:0]   m_tuser;

    segment_scoreboard board;
    int                words_sent;
    int                cycles = 0;
    bit                hold_done;

    timeline_segment_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[timeline_segment_table] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tuser, m_tdata);

    function bit quiet_window();
        return words_sent >= 200 && words_sent < 280;
    endfunction

    initial
    begin
        m_tready <= 1'b0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && words_sent >= 60)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1;
            end
            else
                m_tready <= quiet_window() || ($urandom_range(0, 99) >= 10);
        end
    end

    task automatic send_command(logic [1:0] act, logic signed [31:0] frame,
                                logic signed [7:0] pos, logic [15:0] src,
                                logic [31:0] off, logic signed [24:0] len);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'b0, len, off, src, pos, frame};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_command(act, frame, pos, src, off, len);
        words_sent++;
        if (!quiet_window() && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_random();
        logic [1:0]         act;
        logic signed [31:0] frame;
        logic signed [7:0]  pos;
        logic signed [24:0] len;
        int                 pick;
        int                 span;
        pick = $urandom_range(0, 99);
        act  = pick < 40 ? tst_pkg::ACT_INSERT : pick < 80 ? tst_pkg::ACT_LOOKUP :
               pick < 90 ? tst_pkg::ACT_REPLACE : tst_pkg::ACT_READ;
        span = board.timeline_end();
        if ($urandom_range(0, 99) < 85)
            frame = $urandom_range(0, span + 4);
        else
            frame = $urandom;
        if ($urandom_range(0, 99) < 80)
            pos = 8'($urandom_range(0, board.seg_count));
        else
            pos = 8'(int'($urandom_range(0, 128)) - 64);
        pick = $urandom_range(0, 99);
        if (pick < 3)
            len = $urandom_range(0, 1) ? 25'sd0 : -25'sd1;
        else if (pick < 8)
            len = 25'($urandom_range(1, MAX_LEN));
        else
            len = 25'($urandom_range(1, 2000));
        send_command(act, frame, pos, 16'($urandom), 32'($urandom), len);
    endtask

    initial
    begin
        board      = new();
        words_sent = 0;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= tst_pkg::ACT_LOOKUP;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(tst_pkg::ACT_LOOKUP, 0, 8'sd0, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_LOOKUP, -1, 8'sd0, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_READ, 0, 8'sd0, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_REPLACE, 0, 8'sd0, 16'h0, 32'h0, 25'sd5);
        send_command(tst_pkg::ACT_INSERT, 0, 8'sd0, 16'h1, 32'h0, 25'sd0);
        send_command(tst_pkg::ACT_INSERT, 0, 8'sd0, 16'h1, 32'h0, -25'sd1);
        send_command(tst_pkg::ACT_INSERT, 0, 8'sd1, 16'h1, 32'h0, 25'sd3);
        send_command(tst_pkg::ACT_INSERT, 0, -8'sd5, 16'hFFFF, 32'h80000000, 25'(MAX_LEN));
        send_command(tst_pkg::ACT_INSERT, 0, 8'sd1, 16'h0000, 32'h7FFFFFFF, 25'sd1);
        send_command(tst_pkg::ACT_INSERT, 0, -8'sd1, 16'h1234, 32'h00000010, 25'sd100);
        send_command(tst_pkg::ACT_READ, 0, 8'sd0, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_READ, 0, 8'sd2, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_READ, 0, -8'sd1, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_READ, 0, 8'sd3, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_INSERT, 0, 8'sd4, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_LOOKUP, 0, 8'sd0, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_LOOKUP, MAX_LEN - 1, 8'sd0, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_LOOKUP, MAX_LEN + 100, 8'sd0, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_LOOKUP, MAX_LEN + 101, 8'sd0, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_LOOKUP, 32'sh7FFFFFFF, 8'sd0, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_LOOKUP, 32'sh80000000, 8'sd0, 16'h0, 32'h0, 25'sd1);
        send_command(tst_pkg::ACT_REPLACE, 0, 8'sd1, 16'hABCD, 32'hFFFFFFFF, 25'sd7);
        send_command(tst_pkg::ACT_REPLACE, 0, 8'sd2, 16'h0, 32'h0, 25'sd0);
        send_command(tst_pkg::ACT_REPLACE, 0, 8'sd3, 16'h0, 32'h0, 25'sd7);
        send_command(tst_pkg::ACT_LOOKUP, 3, 8'sd0, 16'h0, 32'h0, 25'sd1);

        repeat (400) send_random();
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.mismatches == 0)
            $display("[timeline_segment_table] OK");
        else
            $display("[timeline_segment_table] ERROR");
        $finish;
    end
endmodule
